// File: hdl/bafff_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap allocator package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bafff_pkg;

	// Store geometry: one mark per element, eight marks to a byte.
	localparam int MAX_ELEMENTS = 1024;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int BYTE_AW      = IDX_W - 3;
	localparam int STORE_BYTES  = MAX_ELEMENTS / 8;
	localparam int NBYTES_W     = CNT_W - 3;

	localparam logic [7:0] FULL_BYTE = 8'hFF;

	// Request codes.
	localparam logic [1:0] ACT_SET   = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_FIND  = 2'd3;

	// Result status codes.
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_RANGE  = 2'd1;
	localparam logic [1:0] STAT_NOFREE = 2'd2;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_MODIFY,
		S_SCAN,
		S_RESP
	} state_t;

	// Which result the datapath loads into its result registers.
	typedef enum logic [2:0] {
		RES_NONE,
		RES_RANGE,
		RES_ACCESS,
		RES_FOUND,
		RES_NOFREE
	} res_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     accept;    // capture the request fields
		logic     wr_acc;    // write back the modified byte
		logic     scan_clr;  // restart the find scan at byte zero
		logic     scan_run;  // advance the find scan by one byte
		res_sel_t res_sel;   // result to load
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_find;
		logic is_read;
		logic in_range;
		logic scan_hit;
		logic scan_end;
	} dp_stat_t;

endpackage

// File: hdl/bitmap_allocator_find_first_free_core.sv
// ----------------------------------------------------------------------------
// Bitmap allocator with find-first-free
// Keeps one allocation mark per element and serves set, clear, read and find.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done high, and the receiver cannot stall
// it. An index at or beyond the effective count gets a range status. A find
// reads the mark store one byte per cycle through its single read port and
// stops at the first byte that holds a free mark; it scans up to the
// effective count, which is the active count saturated at 1024 and rounded
// down to whole bytes. All marks are free after reset; no clearing pass is
// needed. The user must write the active count through the cfg channel only
// while the block is idle; the block itself does not enforce this. A count
// write keeps the marks.
module bitmap_allocator_find_first_free_core
	import bafff_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       action,
	input  logic [IDX_W-1:0] elem_index,
	output logic             done,
	output logic             bit_value,
	output logic [IDX_W-1:0] free_index,
	output logic [1:0]       status,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] active_elements
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// The count register takes a transfer in any cycle.
	assign cfg_ready = 1'b1;

	bafff_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	bafff_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.action     (action),
		.elem_index (elem_index),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (active_elements),
		.bit_value  (bit_value),
		.free_index (free_index),
		.status     (status)
	);

endmodule

// File: hdl/bafff_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bafff_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/bafff_dp.sv
// ----------------------------------------------------------------------------
// Bitmap allocator datapath
// Mark store with per-byte valid bits, scan pipeline and result registers.
// ----------------------------------------------------------------------------
module bafff_dp
	import bafff_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         cmd,
	output dp_stat_t          stat,
	input  logic [1:0]        action,
	input  logic [IDX_W-1:0]  elem_index,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_data,
	output logic              bit_value,
	output logic [IDX_W-1:0]  free_index,
	output logic [1:0]        status
);

	logic [CNT_W-1:0]    active_q;
	logic [1:0]          action_q;
	logic [IDX_W-1:0]    idx_q;
	logic [CNT_W-1:0]    cnt_sat;
	logic [NBYTES_W-1:0] nbytes;
	logic [CNT_W-1:0]    eff_count;
	logic [STORE_BYTES-1:0] vld_q;
	logic                vld_s1;
	logic [BYTE_AW-1:0]  raddr;
	logic [7:0]          rdata;
	logic [7:0]          byte_s1;
	logic [7:0]          mask;
	logic [7:0]          wdata;
	logic [NBYTES_W-1:0] scan_addr_q;
	logic                rd_pend_s1;
	logic [BYTE_AW-1:0]  rd_addr_s1;
	logic                scan_issue;
	logic [2:0]          zero_pos;
	logic                bit_value_q;
	logic [IDX_W-1:0]    free_index_q;
	logic [1:0]          status_q;

	// Count register; it resets to full capacity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= CNT_W'(MAX_ELEMENTS);
		end else if (cfg_we) begin
			active_q <= cfg_data;
		end
	end

	// Effective count: saturated at capacity, rounded down to whole bytes.
	assign cnt_sat   = (active_q > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : active_q;
	assign nbytes    = cnt_sat[CNT_W-1:3];
	assign eff_count = {nbytes, 3'b000};

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			action_q <= action;
			idx_q    <= elem_index;
		end
	end

	// Scan address counter and read-tag pipeline.
	assign scan_issue = cmd.scan_run && (scan_addr_q < nbytes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
			rd_pend_s1  <= 1'b0;
		end else if (cmd.scan_clr) begin
			scan_addr_q <= '0;
			rd_pend_s1  <= 1'b0;
		end else begin
			if (scan_issue) begin
				scan_addr_q <= scan_addr_q + NBYTES_W'(1);
			end
			rd_pend_s1 <= scan_issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= raddr;
	end

	// The read port serves the scan or the addressed byte.
	assign raddr = cmd.scan_run ? scan_addr_q[BYTE_AW-1:0] : idx_q[IDX_W-1:3];

	bafff_ram #(
		.WIDTH (8),
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (cmd.wr_acc),
		.waddr (idx_q[IDX_W-1:3]),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Valid bits: a byte never written since reset reads as all free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (cmd.wr_acc) begin
				vld_q[idx_q[IDX_W-1:3]] <= 1'b1;
			end
			vld_s1 <= vld_q[raddr];
		end
	end

	assign byte_s1 = vld_s1 ? rdata : 8'h00;

	// Read-modify-write of the addressed byte.
	assign mask  = 8'h01 << idx_q[2:0];
	assign wdata = (action_q == ACT_SET) ? (byte_s1 | mask) : (byte_s1 & ~mask);

	// Lowest clear bit of the scanned byte.
	always_comb begin
		zero_pos = 3'd0;
		for (int k = 7; k >= 0; k--) begin
			if (!byte_s1[k]) begin
				zero_pos = 3'(k);
			end
		end
	end

	// Status toward the controller.
	assign stat.is_find  = (action_q == ACT_FIND);
	assign stat.is_read  = (action_q == ACT_READ);
	assign stat.in_range = ({1'b0, idx_q} < eff_count);
	assign stat.scan_hit = rd_pend_s1 && (byte_s1 != FULL_BYTE);
	assign stat.scan_end = !rd_pend_s1 && (scan_addr_q >= nbytes);

	// Result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_value_q  <= 1'b0;
			free_index_q <= '0;
			status_q     <= STAT_OK;
		end else begin
			unique case (cmd.res_sel)
				RES_NONE: begin
				end
				RES_RANGE: begin
					bit_value_q  <= 1'b0;
					free_index_q <= '0;
					status_q     <= STAT_RANGE;
				end
				RES_ACCESS: begin
					bit_value_q  <= (action_q == ACT_READ) ? byte_s1[idx_q[2:0]] : 1'b0;
					free_index_q <= '0;
					status_q     <= STAT_OK;
				end
				RES_FOUND: begin
					bit_value_q  <= 1'b0;
					free_index_q <= {rd_addr_s1, zero_pos};
					status_q     <= STAT_OK;
				end
				RES_NOFREE: begin
					bit_value_q  <= 1'b0;
					free_index_q <= '0;
					status_q     <= STAT_NOFREE;
				end
				default: begin
				end
			endcase
		end
	end

	assign bit_value  = bit_value_q;
	assign free_index = free_index_q;
	assign status     = status_q;

	// A write-back never lands outside the active elements.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_acc |-> stat.in_range)
		else $error("bafff_dp: write-back outside the active range");

	// The scan never reads beyond the active bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> ({1'b0, rd_addr_s1} < nbytes))
		else $error("bafff_dp: scan read beyond the active bytes");

	// A find result always points into the active elements.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res_sel == RES_FOUND) |=> ({1'b0, free_index_q} < eff_count))
		else $error("bafff_dp: found index outside the active range");

endmodule

// File: hdl/bafff_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap allocator controller
// Sequences request capture, byte access, find scan and result strobe.
// ----------------------------------------------------------------------------
module bafff_ctrl
	import bafff_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd,
	output logic      busy,
	output logic      done
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.wr_acc   = 1'b0;
		cmd.scan_clr = 1'b0;
		cmd.scan_run = 1'b0;
		cmd.res_sel  = RES_NONE;
		busy         = 1'b1;
		done         = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.is_find) begin
					cmd.scan_clr = 1'b1;
					state_d      = S_SCAN;
				end else if (!stat.in_range) begin
					cmd.res_sel = RES_RANGE;
					state_d     = S_RESP;
				end else begin
					state_d = S_MODIFY;
				end
			end
			S_MODIFY: begin
				// A read leaves the byte as it is; set and clear write it back.
				cmd.wr_acc  = !stat.is_read;
				cmd.res_sel = RES_ACCESS;
				state_d     = S_RESP;
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.scan_hit) begin
					cmd.res_sel = RES_FOUND;
					state_d     = S_RESP;
				end else if (stat.scan_end) begin
					cmd.res_sel = RES_NOFREE;
					state_d     = S_RESP;
				end
			end
			S_RESP: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Busy rises only after a request transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("bafff_ctrl: busy without a request");

	// The result strobe returns the controller to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("bafff_ctrl: still busy after the result strobe");

	// A write-back happens only for set and clear, never during a find or read.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_acc |-> (state_q == S_MODIFY) && !stat.is_find && !stat.is_read)
		else $error("bafff_ctrl: write-back outside an access");

endmodule
